FILE: design/barr_pkg.sv
// Shared types and constants for the bit array range rotate block.
`default_nettype none

package barr_pkg;

  // Fixed field widths
  localparam int CmdW  = 2;
  localparam int IdxW  = 10;
  localparam int LenW  = 11;
  localparam int AmtW  = 16;
  localparam int SizeW = 12;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_ROTATE = 2'd2
  } cmd_e;

  // Status codes
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_BOUNDS = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT_RMW,
    ST_MOD,
    ST_CP_RD,
    ST_CP_WR,
    ST_WB_RD,
    ST_WB_WR,
    ST_FINISH
  } state_e;

  // Input request payload
  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [IdxW-1:0]        bit_pos;
    logic                   bit_value;
    logic [IdxW-1:0]        range_start;
    logic [LenW-1:0]        range_length;
    logic signed [AmtW-1:0] right_amount;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic read_bit;
    logic status;
  } out_rsp_t;

  // Remainder unit control
  typedef struct packed {
    logic            start;
    logic [AmtW-1:0] dividend;
    logic [LenW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

FILE: design/barr_mod_unit.sv
// Iterative remainder unit: one dividend bit per cycle, shared compare and subtract.
`default_nettype none

module barr_mod_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire barr_pkg::mod_req_t req_i,
  output barr_pkg::mod_rsp_t      rsp_o
);

  localparam int CntW = $clog2(barr_pkg::AmtW + 1);

  logic                       busy_q, busy_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [barr_pkg::AmtW-1:0]  dvd_q, dvd_d;
  logic [barr_pkg::LenW-1:0]  dvs_q, dvs_d;
  logic [barr_pkg::LenW-1:0]  rem_q, rem_d;
  logic                       done_q, done_d;
  logic [barr_pkg::LenW:0]    trial;
  logic [barr_pkg::LenW:0]    diff;

  // Shift in the next dividend bit and subtract the divisor when it fits
  assign trial = {rem_q, dvd_q[barr_pkg::AmtW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[barr_pkg::LenW-1:0];
      end else begin
        rem_d = trial[barr_pkg::LenW-1:0];
      end
      dvd_d = {dvd_q[barr_pkg::AmtW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(barr_pkg::AmtW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: design/bit_array_range_rotate.sv
// Top level: bit store with read, write and sub-range rotate commands.
//
// Requests arrive on in_valid_i/in_ready_o carrying in_req_i; each request
// gives exactly one result on out_valid_o/out_ready_i carrying out_rsp_o.
// The size register (array_bits) is written through cfg_valid_i/cfg_ready_o
// with cfg_data_i; its reset value is 1024. The user must write it only while
// the block is idle; the block itself does not enforce this.
// After reset the byte store is swept to zero, one byte a cycle, over all
// (MAX_BITS+7)/8 bytes (128 at the default), during which no request is taken.
// A read or write reads the store at the accepting edge, takes the bit or
// merges and writes it in ST_BIT_RMW, and loads the output register in ST_FINISH.
// A rotate runs the remainder unit on the distance, then copies the range into
// a scratch memory and writes it back rotated, each bit taking a read state
// and a write state in each pass. Out of bounds, empty or unknown requests go
// straight to ST_FINISH, a distance that reduces to zero once the remainder
// unit is done.
// One request is in work at a time; the next may be accepted while the
// previous result still waits in the output register. If the receiver
// stalls, a finished result holds in the sequencer until that register frees.
`default_nettype none

module bit_array_range_rotate #(
  parameter int MAX_BITS = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire barr_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output barr_pkg::out_rsp_t      out_rsp_o
);

  localparam int StoreBytes = (MAX_BITS + 7) / 8;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int ScrDepth   = (MAX_BITS < 2048) ? MAX_BITS : 2048;
  localparam int ScrW       = $clog2(ScrDepth);
  localparam logic [barr_pkg::SizeW-1:0] CapBits =
    (MAX_BITS > 2047) ? 12'd2047 : 12'(MAX_BITS);

  localparam int LenW = barr_pkg::LenW;

  barr_pkg::state_e   state_q, state_d;
  barr_pkg::in_req_t  req_q, req_d;
  logic               status_q, status_d;
  logic               rbit_q, rbit_d;
  logic [LenW-1:0]    i_q, i_d;
  logic [LenW-1:0]    j_q, j_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [LenW-1:0]    array_bits_q;
  logic               out_valid_q, out_valid_d;
  barr_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  // Store and scratch memories
  logic [7:0]         store_mem [StoreBytes];
  logic [7:0]         store_rdata_q;
  logic               store_rd_en;
  logic [AddrW-1:0]   store_rd_addr;
  logic               store_wr_en;
  logic [AddrW-1:0]   store_wr_addr;
  logic [7:0]         store_wr_data;
  logic               scr_mem [ScrDepth];
  logic               scr_rdata_q;
  logic               scr_rd_en;
  logic               scr_wr_en;
  logic               scr_wr_data;

  barr_pkg::mod_req_t mod_req;
  barr_pkg::mod_rsp_t mod_rsp;

  logic [barr_pkg::SizeW-1:0] size;
  logic [barr_pkg::SizeW-1:0] range_end;
  logic                       idx_oob;
  logic                       in_fire;
  logic                       out_free;
  logic [LenW-1:0]            pos;
  logic [AddrW-1:0]           pos_addr;
  logic [AddrW-1:0]           idx_addr;
  logic [AddrW-1:0]           idx_q_addr;
  logic [LenW-1:0]            rot_k;
  logic [LenW-1:0]            i_inc;
  logic [barr_pkg::AmtW-1:0]  amt_mag;

  barr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Usable size and bounds checks on the incoming request
  always_comb begin
    size = ({1'b0, array_bits_q} < CapBits) ? {1'b0, array_bits_q} : CapBits;
    range_end = {2'b00, in_req_i.range_start} + {1'b0, in_req_i.range_length};
    idx_oob = ({2'b00, in_req_i.bit_pos} >= size);
  end

  assign in_ready_o  = (state_q == barr_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Position of the current bit within the store
  assign pos        = {1'b0, req_q.range_start} + i_q;
  assign i_inc      = i_q + 1'b1;
  assign pos_addr   = AddrW'(pos[LenW-1:3]);
  assign idx_addr   = AddrW'(in_req_i.bit_pos[barr_pkg::IdxW-1:3]);
  assign idx_q_addr = AddrW'(req_q.bit_pos[barr_pkg::IdxW-1:3]);

  // Magnitude of the distance and final rotate amount
  assign amt_mag = in_req_i.right_amount[barr_pkg::AmtW-1] ?
                   (~in_req_i.right_amount + 1'b1) : in_req_i.right_amount;
  always_comb begin
    if (req_q.right_amount[barr_pkg::AmtW-1] && (mod_rsp.rem != '0)) begin
      rot_k = req_q.range_length - mod_rsp.rem;
    end else begin
      rot_k = mod_rsp.rem;
    end
  end

  // Sequencer: next state and memory controls
  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    status_d      = status_q;
    rbit_d        = rbit_q;
    i_d           = i_q;
    j_d           = j_q;
    clr_d         = clr_q;
    store_rd_en   = 1'b0;
    store_rd_addr = pos_addr;
    store_wr_en   = 1'b0;
    store_wr_addr = pos_addr;
    store_wr_data = store_rdata_q;
    scr_rd_en     = 1'b0;
    scr_wr_en     = 1'b0;
    scr_wr_data   = store_rdata_q[pos[2:0]];
    mod_req.start    = 1'b0;
    mod_req.dividend = amt_mag;
    mod_req.divisor  = in_req_i.range_length;

    case (state_q)
      barr_pkg::ST_CLEAR: begin
        store_wr_en   = 1'b1;
        store_wr_addr = clr_q;
        store_wr_data = '0;
        clr_d         = clr_q + 1'b1;
        if (clr_q == AddrW'(StoreBytes - 1)) begin
          state_d = barr_pkg::ST_IDLE;
        end
      end

      barr_pkg::ST_IDLE: begin
        if (in_fire) begin
          req_d    = in_req_i;
          status_d = barr_pkg::STAT_OK;
          rbit_d   = 1'b0;
          i_d      = '0;
          case (barr_pkg::cmd_e'(in_req_i.cmd))
            barr_pkg::CMD_READ, barr_pkg::CMD_WRITE: begin
              if (idx_oob) begin
                status_d = barr_pkg::STAT_BOUNDS;
                state_d  = barr_pkg::ST_FINISH;
              end else begin
                store_rd_en   = 1'b1;
                store_rd_addr = idx_addr;
                state_d       = barr_pkg::ST_BIT_RMW;
              end
            end
            barr_pkg::CMD_ROTATE: begin
              if (range_end > size) begin
                status_d = barr_pkg::STAT_BOUNDS;
                state_d  = barr_pkg::ST_FINISH;
              end else if (in_req_i.range_length == '0) begin
                state_d = barr_pkg::ST_FINISH;
              end else begin
                mod_req.start = 1'b1;
                state_d       = barr_pkg::ST_MOD;
              end
            end
            default: begin
              status_d = barr_pkg::STAT_BOUNDS;
              state_d  = barr_pkg::ST_FINISH;
            end
          endcase
        end
      end

      barr_pkg::ST_BIT_RMW: begin
        if (barr_pkg::cmd_e'(req_q.cmd) == barr_pkg::CMD_READ) begin
          rbit_d = store_rdata_q[req_q.bit_pos[2:0]];
        end else begin
          store_wr_en   = 1'b1;
          store_wr_addr = idx_q_addr;
          store_wr_data[req_q.bit_pos[2:0]] = req_q.bit_value;
        end
        state_d = barr_pkg::ST_FINISH;
      end

      barr_pkg::ST_MOD: begin
        if (mod_rsp.done) begin
          if (rot_k == '0) begin
            state_d = barr_pkg::ST_FINISH;
          end else begin
            j_d     = req_q.range_length - rot_k;
            state_d = barr_pkg::ST_CP_RD;
          end
        end
      end

      // Copy the range into scratch, one bit per pass
      barr_pkg::ST_CP_RD: begin
        store_rd_en = 1'b1;
        state_d     = barr_pkg::ST_CP_WR;
      end

      barr_pkg::ST_CP_WR: begin
        scr_wr_en = 1'b1;
        if (i_inc == req_q.range_length) begin
          i_d     = '0;
          state_d = barr_pkg::ST_WB_RD;
        end else begin
          i_d     = i_inc;
          state_d = barr_pkg::ST_CP_RD;
        end
      end

      // Write the rotated bits back with a read-modify-write per bit
      barr_pkg::ST_WB_RD: begin
        store_rd_en = 1'b1;
        scr_rd_en   = 1'b1;
        state_d     = barr_pkg::ST_WB_WR;
      end

      barr_pkg::ST_WB_WR: begin
        store_wr_en = 1'b1;
        store_wr_data[pos[2:0]] = scr_rdata_q;
        if ((j_q + 1'b1) == req_q.range_length) begin
          j_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
        i_d = i_inc;
        if (i_inc == req_q.range_length) begin
          state_d = barr_pkg::ST_FINISH;
        end else begin
          state_d = barr_pkg::ST_WB_RD;
        end
      end

      barr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = barr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = barr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: load on finish, drop on handshake
  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == barr_pkg::ST_FINISH) && out_free) begin
      out_valid_d        = 1'b1;
      out_rsp_d.read_bit = rbit_q;
      out_rsp_d.status   = status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= barr_pkg::ST_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      array_bits_q <= 11'd1024;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        array_bits_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    status_q  <= status_d;
    rbit_q    <= rbit_d;
    i_q       <= i_d;
    j_q       <= j_d;
    out_rsp_q <= out_rsp_d;
  end

  // Byte store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (store_wr_en) begin
      store_mem[store_wr_addr] <= store_wr_data;
    end
    if (store_rd_en) begin
      store_rdata_q <= store_mem[store_rd_addr];
    end
  end

  // Scratch bit memory for the range being rotated
  always_ff @(posedge clk_i) begin
    if (scr_wr_en) begin
      scr_mem[i_q[ScrW-1:0]] <= scr_wr_data;
    end
    if (scr_rd_en) begin
      scr_rdata_q <= scr_mem[j_q[ScrW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: design/barr_checker.sv
// Port-level checks for the bit array range rotate block, bound to the top level.
`default_nettype none

module barr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire barr_pkg::out_rsp_t out_rsp_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // One request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in work");

  // A bit is only returned on a successful request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.read_bit |-> out_rsp_o.status == barr_pkg::STAT_OK)
    else $error("read bit set on a failed request");

  // A new result follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

endmodule

bind bit_array_range_rotate barr_checker u_barr_checker (.*);

`default_nettype wire

FILE: sim/bit_array_range_rotate_test.sv
// Self-checking testbench for bit_array_range_rotate: directed table, then random request phases.
module bit_array_range_rotate_test;

  localparam int MAX_BITS = 1024;
  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 50;
  localparam int RANDOM_PER_PHASE = 111;
  localparam int NUM_PHASES = 5;
  localparam int NUM_DIRECTED = 29;
  localparam logic [barr_pkg::CmdW-1:0] CMD_UNKNOWN = 2'd3;

  typedef enum logic {ROW_REQUEST, ROW_SET_SIZE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [10:0]        size_value;
    barr_pkg::in_req_t  req;
    logic               checked;
    barr_pkg::out_rsp_t want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [10:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  barr_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  barr_pkg::out_rsp_t out_rsp_o;

  // Shadow copy of the block's state
  logic [7:0]  shadow_bytes [STORE_BYTES];
  logic [10:0] array_size;

  barr_pkg::out_rsp_t awaited_responses [$];
  int       error_count;
  int       result_count;
  int       cycle_count;
  int       send_idle_pct;
  int       stall_pct;
  int       holdoff_request;

  // Directed requests; rows with checked set carry the obvious answer
  script_row_t directed_steps [NUM_DIRECTED] = '{
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd1023, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_WRITE, 10'd0, 1'b1, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_WRITE, 10'd1023, 1'b1, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b1, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd1023, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b1, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd0, 11'd1024, 16'sd1},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd24, 11'd1000, 16'sh8000},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd1023, 11'd1, 16'sh7FFF},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd3, 11'd0, 16'sd5},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd10, 11'd8, 16'sd8},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd1, 11'd1024, 16'sd3},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd1023, 11'd2, 16'sd1},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{CMD_UNKNOWN, 10'd1023, 1'b1, 10'd1023, 11'h7FF, 16'sh7FFF},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd0, 11'd40, -16'sd7},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_SET_SIZE, 11'd100,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd100, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_WRITE, 10'd99, 1'b1, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_WRITE, 10'd100, 1'b1, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd90, 11'd10, 16'sd3},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd91, 11'd10, 16'sd3},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_SET_SIZE, 11'd0,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_WRITE, 10'd0, 1'b1, 10'd0, 11'd0, 16'sd0},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd1},
      1'b1, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd0, 11'd1, 16'sd1},
      1'b1, '{1'b0, barr_pkg::STAT_BOUNDS}},
    '{ROW_SET_SIZE, 11'd2047,
      '{barr_pkg::CMD_READ, 10'd0, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_READ, 10'd1023, 1'b0, 10'd0, 11'd0, 16'sd0},
      1'b0, '{1'b0, barr_pkg::STAT_OK}},
    '{ROW_REQUEST, 11'd0,
      '{barr_pkg::CMD_ROTATE, 10'd0, 1'b0, 10'd0, 11'd1024, 16'sd1000},
      1'b0, '{1'b0, barr_pkg::STAT_OK}}
  };

  bit_array_range_rotate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic fetch_bit(logic [9:0] pos);
    return shadow_bytes[pos[9:3]][pos[2:0]];
  endfunction

  function automatic void store_bit(logic [9:0] pos, logic v);
    shadow_bytes[pos[9:3]][pos[2:0]] = v;
  endfunction

  // Apply one request to the shadow store and return its result
  function automatic barr_pkg::out_rsp_t execute_command(barr_pkg::in_req_t r);
    barr_pkg::out_rsp_t rsp;
    int unsigned usable;
    int unsigned start;
    int unsigned len;
    int          span;
    int          amt;
    int          shift;
    logic        held [MAX_BITS];
    rsp.read_bit = 1'b0;
    rsp.status = barr_pkg::STAT_OK;
    usable = (array_size < MAX_BITS) ? int'(array_size) : MAX_BITS;
    start = r.range_start;
    len = r.range_length;
    case (r.cmd)
      barr_pkg::CMD_READ: begin
        if (r.bit_pos < usable) rsp.read_bit = fetch_bit(r.bit_pos);
        else rsp.status = barr_pkg::STAT_BOUNDS;
      end
      barr_pkg::CMD_WRITE: begin
        if (r.bit_pos < usable) store_bit(r.bit_pos, r.bit_value);
        else rsp.status = barr_pkg::STAT_BOUNDS;
      end
      barr_pkg::CMD_ROTATE: begin
        if (start + len > usable) begin
          rsp.status = barr_pkg::STAT_BOUNDS;
        end else if (len != 0) begin
          span = int'(len);
          amt = int'(r.right_amount);
          shift = ((amt % span) + span) % span;
          if (shift != 0) begin
            for (int i = 0; i < span; i++) held[i] = fetch_bit(10'(int'(start) + i));
            for (int i = 0; i < span; i++)
              store_bit(10'(int'(start) + i), held[(i + span - shift) % span]);
          end
        end
      end
      default: rsp.status = barr_pkg::STAT_BOUNDS;
    endcase
    return rsp;
  endfunction

  // Mostly well-formed requests inside the array, with some noise
  function automatic barr_pkg::in_req_t make_random_request(int unsigned size,
                                                            int unsigned serial);
    barr_pkg::in_req_t r;
    int unsigned pick;
    int unsigned len;
    int unsigned top;
    int          amt;
    r.cmd = 2'($urandom);
    r.bit_pos = 10'($urandom);
    r.bit_value = 1'($urandom);
    r.range_start = 10'($urandom);
    r.range_length = 11'($urandom);
    r.right_amount = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) r.cmd = barr_pkg::CMD_READ;
    else if (pick < 60) r.cmd = barr_pkg::CMD_WRITE;
    else if (pick < 95) r.cmd = barr_pkg::CMD_ROTATE;
    else r.cmd = CMD_UNKNOWN;
    if ((r.cmd == barr_pkg::CMD_READ || r.cmd == barr_pkg::CMD_WRITE) && size > 0 &&
        $urandom_range(0, 99) < 85)
      r.bit_pos = 10'($urandom_range(0, size - 1));
    if (r.cmd == barr_pkg::CMD_ROTATE) begin
      // keep most ranges short; an occasional long one
      if ($urandom_range(0, 99) < 85) begin
        if (serial % 50 == 0) len = $urandom_range(512, 1024);
        else if ($urandom_range(0, 99) < 90) len = $urandom_range(0, 48);
        else len = $urandom_range(0, 256);
        if (len > size) len = size;
        top = size - len;
        if (top > 1023) top = 1023;
        r.range_length = 11'(len);
        r.range_start = 10'($urandom_range(0, top));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        amt = int'($urandom_range(0, 80)) - 40;
        r.right_amount = 16'(amt);
      end else if (pick >= 85) begin
        // whole turns: no movement
        amt = int'(r.range_length) * (int'($urandom_range(0, 6)) - 3);
        r.right_amount = 16'(amt);
      end
    end
    return r;
  endfunction

  task automatic note_failure(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offer one request, hold it until taken, then record what it should give
  task automatic send_request(barr_pkg::in_req_t r, logic checked,
                              barr_pkg::out_rsp_t want);
    int                 gap;
    barr_pkg::out_rsp_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = execute_command(r);
    awaited_responses.push_back(checked ? want : predicted);
  endtask

  // Write the size register once every result is back
  task automatic write_array_bits(logic [10:0] value);
    in_valid_i <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    array_size = value;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_request > 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Compare each result with the oldest one awaited
  always @(posedge clk_i) begin
    barr_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_responses.size() == 0) begin
        note_failure($sformatf(
          "result %0d arrived with no request outstanding: read_bit %0b status %0b",
          result_count, out_rsp_o.read_bit, out_rsp_o.status));
      end else begin
        want = awaited_responses.pop_front();
        if (out_rsp_o.read_bit !== want.read_bit || out_rsp_o.status !== want.status)
          note_failure($sformatf(
            "result %0d mismatch: read_bit exp %0b got %0b, status exp %0b got %0b",
            result_count, want.read_bit, out_rsp_o.read_bit,
            want.status, out_rsp_o.status));
      end
      result_count++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int          serial;
    int          hold;
    logic [10:0] phase_size;
    error_count = 0;
    result_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_request = 0;
    serial = 0;
    array_size = 11'd1024;
    foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 11'd0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_SET_SIZE)
        write_array_bits(directed_steps[i].size_value);
      else
        send_request(directed_steps[i].req, directed_steps[i].checked,
                     directed_steps[i].want);
    end

    // Random phases, each with its own size and idling pattern
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      hold = 0;
      case (phase)
        0: begin phase_size = 11'd1024; send_idle_pct = 0;  stall_pct = 0;  end
        1: begin phase_size = 11'd37;   send_idle_pct = 69; stall_pct = 0;  end
        2: begin phase_size = 11'd1;    send_idle_pct = 0;  stall_pct = 69; end
        3: begin phase_size = 11'd640;  send_idle_pct = 35; stall_pct = 35; end
        default: begin
          phase_size = 11'd1024; send_idle_pct = 0; stall_pct = 0; hold = 3000;
        end
      endcase
      write_array_bits(phase_size);
      holdoff_request = hold;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_request(make_random_request(array_size, serial), 1'b0, '0);
        serial++;
      end
    end

    // Drain
    in_valid_i <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
